// File: rtl/salc_pkg.sv
// Package: payload types, register map and sizing constants for the LRU cache lookup.
package salc_pkg;

  // Field widths fixed by the interface
  localparam int unsigned ADDR_FIELD_W   = 32;
  localparam int unsigned WAY_FIELD_W    = 3;
  localparam int unsigned AGE_W          = 3;
  localparam logic [AGE_W-1:0] AGE_MAX   = 3'd7;
  localparam int unsigned INDEX_BITS_CAP = 16;

  // Configuration port
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned PDATA_W = 32;
  localparam int unsigned PADDR_W = 4;

  localparam logic [1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [1:0] REG_WAYS_USED   = 2'd2;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd4;
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd7;
  localparam logic [CFG_W-1:0] WAYS_USED_RST   = 4'd1;

  // Operation codes
  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Default sizing
  localparam int unsigned MAX_WAYS_DEFAULT      = 8;
  localparam int unsigned MAX_SETS_DEFAULT      = 1024;
  localparam int unsigned ADDRESS_WIDTH_DEFAULT = 32;

  typedef struct packed {
    logic                    op;
    logic [ADDR_FIELD_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic                   hit;
    logic [WAY_FIELD_W-1:0] way;
  } rsp_t;

endpackage

// File: rtl/set_associative_lru_cache_lookup_core.sv
// Top level: set-associative LRU cache lookup, one access per cycle when not stalled.
//
// Takes one access address or a flush per request beat and returns one response beat
// (hit flag and way) per request, in order. The block is pipelined and takes a new
// access in every cycle unless a held response or a flush stalls it: a request goes
// through an input register, an index stage (block offset shift, index mask and set
// number modulo MAX_SETS by reciprocal multiply), a memory stage that reads the
// set's tags and valid/age row, and a lookup stage that compares every way in
// parallel, picks the victim, updates the ages and writes the row back in the same
// cycle. The rate is set by the tag and state memories, each read once and written
// once per access; a write-to-read bypass covers back-to-back accesses to the same
// set. A flush clears the valid bits and ages with a pass over the state memory, one
// set per cycle, so req_ready stays low from a flush's acceptance, and from reset,
// until that pass ends; configuration writes are taken throughout. Tags are never
// cleared: they are only looked at behind a valid bit.
// Registers sit at byte addresses 0 (offset_bits), 4 (index_bits) and 8 (ways_used).
module set_associative_lru_cache_lookup_core
  import salc_pkg::*;
#(
  parameter int unsigned MAX_WAYS      = MAX_WAYS_DEFAULT,
  parameter int unsigned MAX_SETS      = MAX_SETS_DEFAULT,
  parameter int unsigned ADDRESS_WIDTH = ADDRESS_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_ready,
  input  req_t               req,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rsp_t               rsp,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int unsigned ADDR_W = (ADDRESS_WIDTH < ADDR_FIELD_W) ? ADDRESS_WIDTH
                                                                  : ADDR_FIELD_W;
  localparam int unsigned TAG_W  = ADDR_W;
  localparam int unsigned V_W    = INDEX_BITS_CAP;
  // Reciprocal for an exact quotient of any V_W-bit value by MAX_SETS
  localparam int unsigned RCP_SH = V_W + SET_W;
  localparam int unsigned RCP_W  = V_W + 2;
  localparam int unsigned PROD_W = V_W + RCP_W;
  localparam longint unsigned RCP_M = ((64'd1 << RCP_SH) / MAX_SETS) + 64'd1;
  localparam int unsigned NW_W   = CFG_W + 1;

  typedef struct packed {
    logic [MAX_WAYS-1:0][AGE_W-1:0] age;
    logic [MAX_WAYS-1:0]            valid;
  } meta_t;

  typedef logic [MAX_WAYS-1:0][TAG_W-1:0] tag_row_t;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] offset_bits;
  logic [CFG_W-1:0] index_bits;
  logic [CFG_W-1:0] ways_used;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OFFSET_BITS_RST;
      index_bits  <= INDEX_BITS_RST;
      ways_used   <= WAYS_USED_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_OFFSET_BITS: offset_bits <= pwdata[CFG_W-1:0];
        REG_INDEX_BITS:  index_bits  <= pwdata[CFG_W-1:0];
        REG_WAYS_USED:   ways_used   <= pwdata[CFG_W-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_OFFSET_BITS: prdata = PDATA_W'(offset_bits);
      REG_INDEX_BITS:  prdata = PDATA_W'(index_bits);
      REG_WAYS_USED:   prdata = PDATA_W'(ways_used);
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline control. The whole pipeline advances whenever the response register
  // can take a beat; a held stage re-reads its own set so the memory data stays
  // matched with the item in the lookup stage.
  // ---------------------------------------------------------------------------
  logic             adv;
  logic             req_fire;
  logic             flush_busy;
  logic             clearing;
  logic [SET_W-1:0] clr_cnt;

  logic             s0_valid;
  req_t             s0_req;
  logic             s1_valid;
  logic             s1_op;
  logic [V_W-1:0]   s1_v;
  logic [V_W-1:0]   s1_q;
  logic [TAG_W-1:0] s1_tag;
  logic             s2_valid;
  logic             s2_op;
  logic [SET_W-1:0] s2_set;
  logic [TAG_W-1:0] s2_tag;

  assign adv        = !rsp_valid || rsp_ready;
  assign flush_busy = (s0_valid && (s0_req.op == OP_FLUSH)) ||
                      (s1_valid && (s1_op == OP_FLUSH)) ||
                      (s2_valid && (s2_op == OP_FLUSH));
  // Hold requests off while a flush is in flight or the state memory is being cleared
  assign req_ready  = adv && !clearing && !flush_busy;
  assign req_fire   = req_valid && req_ready;

  // ---------------------------------------------------------------------------
  // Index stage: split the address into set value and tag, start the modulo
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] s0_block;
  logic [V_W-1:0]    s0_mask;
  logic [V_W-1:0]    s0_v;
  logic [TAG_W-1:0]  s0_tag;
  logic [PROD_W-1:0] s0_prod;

  assign s0_block = s0_req.address[ADDR_W-1:0] >> offset_bits;
  assign s0_mask  = ~({V_W{1'b1}} << index_bits);
  assign s0_v     = V_W'(s0_block) & s0_mask;
  assign s0_tag   = TAG_W'(s0_block >> index_bits);
  assign s0_prod  = PROD_W'(s0_v) * PROD_W'(RCP_M);

  // Finish the modulo: remainder is exact, so no correction step
  logic [2*V_W-1:0] s1_qn;
  logic [SET_W-1:0] s1_set;

  assign s1_qn  = (2*V_W)'(s1_q) * (2*V_W)'(MAX_SETS);
  assign s1_set = SET_W'(s1_v - s1_qn[V_W-1:0]);

  // ---------------------------------------------------------------------------
  // Tag and state memories
  // ---------------------------------------------------------------------------
  logic [SET_W-1:0] rd_set;
  logic             meta_we;
  logic [SET_W-1:0] meta_waddr;
  meta_t            meta_wdata;
  meta_t            meta_rdata;
  logic             tag_we;
  tag_row_t         tag_wdata;
  tag_row_t         tag_rdata;
  logic             meta_byp;
  meta_t            meta_byp_data;
  logic             tag_byp;
  tag_row_t         tag_byp_data;

  assign rd_set = adv ? s1_set : s2_set;

  salc_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (MAX_SETS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (rd_set),
    .rdata (meta_rdata)
  );

  salc_ram #(
    .WIDTH ($bits(tag_row_t)),
    .DEPTH (MAX_SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (s2_set),
    .wdata (tag_wdata),
    .raddr (rd_set),
    .rdata (tag_rdata)
  );

  // ---------------------------------------------------------------------------
  // Lookup stage: parallel tag compare, victim choice, LRU age update
  // ---------------------------------------------------------------------------
  function automatic logic [WAY_W-1:0] first_set(input logic [MAX_WAYS-1:0] bits);
    logic [WAY_W-1:0] pos;
    pos = '0;
    for (int i = MAX_WAYS - 1; i >= 0; i--) begin
      if (bits[i]) begin
        pos = WAY_W'(i);
      end
    end
    return pos;
  endfunction

  meta_t               cur_meta;
  tag_row_t            cur_tags;
  logic [NW_W-1:0]     n_ways;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic [MAX_WAYS-1:0] oldest;
  logic                hit;
  logic [WAY_W-1:0]    used;
  logic [AGE_W:0]      old_age;
  meta_t               new_meta;
  tag_row_t            new_tags;
  logic                s2_done;
  logic                s2_access;

  // Take the row just written when it is the set read at the same edge
  assign cur_meta = meta_byp ? meta_byp_data : meta_rdata;
  assign cur_tags = tag_byp ? tag_byp_data : tag_rdata;

  always_comb begin
    if (ways_used == '0) begin
      n_ways = NW_W'(1);
    end else if (NW_W'(ways_used) > NW_W'(MAX_WAYS)) begin
      n_ways = NW_W'(MAX_WAYS);
    end else begin
      n_ways = NW_W'(ways_used);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = NW_W'(i) < n_ways;
      match[i]  = in_use[i] && cur_meta.valid[i] && (cur_tags[i] == s2_tag);
      free[i]   = in_use[i] && !cur_meta.valid[i];
    end
  end

  // A way is oldest when no earlier way is as old and no later way is older
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      oldest[i] = in_use[i];
      for (int j = 0; j < MAX_WAYS; j++) begin
        if (in_use[j]) begin
          if ((j < i) && (cur_meta.age[j] >= cur_meta.age[i])) begin
            oldest[i] = 1'b0;
          end
          if ((j > i) && (cur_meta.age[j] > cur_meta.age[i])) begin
            oldest[i] = 1'b0;
          end
        end
      end
    end
  end

  assign hit = |match;

  always_comb begin
    if (hit) begin
      used = first_set(match);
    end else if (|free) begin
      used = first_set(free);
    end else begin
      used = first_set(oldest);
    end
  end

  // An invalid way ranks older than every age
  assign old_age = cur_meta.valid[used] ? {1'b0, cur_meta.age[used]}
                                        : (AGE_W+1)'(AGE_MAX) + 1'b1;

  always_comb begin
    new_meta = cur_meta;
    new_tags = cur_tags;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (WAY_W'(i) == used) begin
        new_meta.age[i]   = '0;
        new_meta.valid[i] = 1'b1;
        new_tags[i]       = s2_tag;
      end else if (in_use[i] && cur_meta.valid[i] &&
                   ({1'b0, cur_meta.age[i]} < old_age) &&
                   (cur_meta.age[i] != AGE_MAX)) begin
        new_meta.age[i] = cur_meta.age[i] + 1'b1;
      end
    end
  end

  assign s2_done    = adv && s2_valid;
  assign s2_access  = s2_done && (s2_op == OP_ACCESS);

  // Clearing pass owns the state memory's write port; no item is in flight then
  assign meta_we    = clearing || s2_access;
  assign meta_waddr = clearing ? clr_cnt : s2_set;
  assign meta_wdata = clearing ? '0 : new_meta;
  assign tag_we     = !clearing && s2_access;
  assign tag_wdata  = new_tags;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      rsp_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_cnt   <= '0;
      meta_byp  <= 1'b0;
      tag_byp   <= 1'b0;
    end else begin
      if (adv) begin
        s0_valid  <= req_fire;
        s1_valid  <= s0_valid;
        s2_valid  <= s1_valid;
        rsp_valid <= s2_valid;
      end
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == SET_W'(MAX_SETS - 1)) begin
          clearing <= 1'b0;
        end
      end else if (s2_done && (s2_op == OP_FLUSH)) begin
        clearing <= 1'b1;
        clr_cnt  <= '0;
      end
      meta_byp <= meta_we && (meta_waddr == rd_set);
      tag_byp  <= tag_we && (s2_set == rd_set);
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    meta_byp_data <= meta_wdata;
    tag_byp_data  <= tag_wdata;
    if (adv) begin
      s0_req <= req;
      s1_op  <= s0_req.op;
      s1_v   <= s0_v;
      s1_q   <= V_W'(s0_prod >> RCP_SH);
      s1_tag <= s0_tag;
      s2_op  <= s1_op;
      s2_set <= s1_set;
      s2_tag <= s1_tag;
      if (s2_op == OP_FLUSH) begin
        rsp.hit <= 1'b0;
        rsp.way <= '0;
      end else begin
        rsp.hit <= hit;
        rsp.way <= WAY_FIELD_W'(used);
      end
    end
  end

endmodule

// File: rtl/salc_ram.sv
// Generic single-write-port RAM with one registered read port.
module salc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents when the same row is written in the same cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
